### hdl/biphasic_stim_pulse_sequencer_core_assert.svh
// Assertion macros used by the checker file bpsq_checker.sv.
`ifndef BIPHASIC_STIM_PULSE_SEQUENCER_CORE_ASSERT_SVH
`define BIPHASIC_STIM_PULSE_SEQUENCER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpsq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BPSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpsq: next-cycle check failed");

`endif

### hdl/bpsq_pkg.sv
package bpsq_pkg;

  localparam int GAP_TIMER_BITS = 24;
  localparam int MAX_LEVEL      = 15;
  localparam int PWM_MAX_PERIOD = 1024;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_BOOST_PERIOD     = 3'd0;
  localparam logic [2:0] REG_BOOST_ON_TICKS   = 3'd1;
  localparam logic [2:0] REG_PULSES_PER_LEVEL = 3'd2;
  localparam logic [2:0] REG_INTENSITY_LEVEL  = 3'd3;
  localparam logic [2:0] REG_PAIR_COUNT       = 3'd4;
  localparam logic [2:0] REG_TRIG_WIDTH_US    = 3'd5;
  localparam logic [2:0] REG_TRIG_GAP_US      = 3'd6;
  localparam logic [2:0] REG_SENSE_GAP_US     = 3'd7;

  // Phase codes as seen on seq_phase_out
  localparam logic [2:0] PHASE_CODE_IDLE      = 3'd0;
  localparam logic [2:0] PHASE_CODE_BOOST_A   = 3'd1;
  localparam logic [2:0] PHASE_CODE_TRIG_A    = 3'd2;
  localparam logic [2:0] PHASE_CODE_BOOST_B   = 3'd3;
  localparam logic [2:0] PHASE_CODE_TRIG_B    = 3'd4;
  localparam logic [2:0] PHASE_CODE_GAP_TRIG  = 3'd5;
  localparam logic [2:0] PHASE_CODE_GAP_SENSE = 3'd6;

  typedef struct packed {
    logic [10:0]               boost_period;
    logic [10:0]               boost_on_ticks;
    logic [7:0]                pulses_per_level;
    logic [3:0]                intensity_level;
    logic [7:0]                pair_count;
    logic [15:0]               trig_width_us;
    logic [GAP_TIMER_BITS-1:0] trig_gap_us;
    logic [GAP_TIMER_BITS-1:0] sense_gap_us;
  } cfg_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_BOOST_A   = 7'b0000010,
    PH_TRIG_A    = 7'b0000100,
    PH_BOOST_B   = 7'b0001000,
    PH_TRIG_B    = 7'b0010000,
    PH_GAP_TRIG  = 7'b0100000,
    PH_GAP_SENSE = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] reps;
  } enter_t;

endpackage

### hdl/bpsq_cfg_regs.sv
module bpsq_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output bpsq_pkg::cfg_t     cfg
);

  bpsq_pkg::cfg_t cfg_r;
  bpsq_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        bpsq_pkg::REG_BOOST_PERIOD:     cfg_nxt.boost_period     = pwdata[10:0];
        bpsq_pkg::REG_BOOST_ON_TICKS:   cfg_nxt.boost_on_ticks   = pwdata[10:0];
        bpsq_pkg::REG_PULSES_PER_LEVEL: cfg_nxt.pulses_per_level = pwdata[7:0];
        bpsq_pkg::REG_INTENSITY_LEVEL:  cfg_nxt.intensity_level  = pwdata[3:0];
        bpsq_pkg::REG_PAIR_COUNT:       cfg_nxt.pair_count       = pwdata[7:0];
        bpsq_pkg::REG_TRIG_WIDTH_US:    cfg_nxt.trig_width_us    = pwdata[15:0];
        bpsq_pkg::REG_TRIG_GAP_US:
          cfg_nxt.trig_gap_us = pwdata[bpsq_pkg::GAP_TIMER_BITS-1:0];
        bpsq_pkg::REG_SENSE_GAP_US:
          cfg_nxt.sense_gap_us = pwdata[bpsq_pkg::GAP_TIMER_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpsq_pkg::REG_BOOST_PERIOD:     prdata = 32'(cfg_r.boost_period);
      bpsq_pkg::REG_BOOST_ON_TICKS:   prdata = 32'(cfg_r.boost_on_ticks);
      bpsq_pkg::REG_PULSES_PER_LEVEL: prdata = 32'(cfg_r.pulses_per_level);
      bpsq_pkg::REG_INTENSITY_LEVEL:  prdata = 32'(cfg_r.intensity_level);
      bpsq_pkg::REG_PAIR_COUNT:       prdata = 32'(cfg_r.pair_count);
      bpsq_pkg::REG_TRIG_WIDTH_US:    prdata = 32'(cfg_r.trig_width_us);
      bpsq_pkg::REG_TRIG_GAP_US:      prdata = 32'(cfg_r.trig_gap_us);
      bpsq_pkg::REG_SENSE_GAP_US:     prdata = 32'(cfg_r.sense_gap_us);
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boost_period     <= 11'd40;
      cfg_r.boost_on_ticks   <= 11'd29;
      cfg_r.pulses_per_level <= 8'd8;
      cfg_r.intensity_level  <= 4'd1;
      cfg_r.pair_count       <= 8'd6;
      cfg_r.trig_width_us    <= 16'd50;
      cfg_r.trig_gap_us      <= bpsq_pkg::GAP_TIMER_BITS'(3000);
      cfg_r.sense_gap_us     <= bpsq_pkg::GAP_TIMER_BITS'(100000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/biphasic_stim_pulse_sequencer_core.sv
// Channel | Direction | Transaction
// in_     | slave     | one tick: run flag
// out_    | master    | one result per tick: drives, phase, unit end on tlast
// cfg_    | APB slave | register writes and reads, pready tied high
//
// One transaction in, one out; a tick is taken every cycle while the output
// register is empty or being drained (in_tready = !out_tvalid | out_tready).
// The whole phase step, including zero-length phase skipping, is combinational
// between the sequencer state and the output register.
// Synchronous active-low reset clears the sequencer to idle and the registers
// to their defaults; a stalled result holds in the output register.
module biphasic_stim_pulse_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] run, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] boost_drive, [1] pos_drive, [2] neg_drive,
                                  // [5:3] seq_phase_out, [7:6] zero
  output logic        out_tlast,  // unit_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int GB = bpsq_pkg::GAP_TIMER_BITS;

  bpsq_pkg::cfg_t cfg;

  bpsq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Sequencer state
  bpsq_pkg::phase_t phase_r, phase_nxt;
  logic [GB-1:0]    timer_r, timer_nxt;
  logic [10:0]      slot_r, slot_nxt;
  logic [9:0]       pwm_r, pwm_nxt;
  logic [11:0]      pulses_r, pulses_nxt;
  logic [7:0]       reps_r, reps_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  logic in_accept;

  // Derived configuration
  logic [3:0]    lvl_sat;
  logic [11:0]   boost_slots;
  logic [10:0]   pwm_period;
  logic          boost_ok, trig_ok, tgap_ok, sgap_ok;

  // Step intermediates
  logic               start;
  bpsq_pkg::enter_t   ent0, ent1;
  bpsq_pkg::phase_t   ph, next_ph;
  logic [GB-1:0]      timer_s;
  logic [10:0]        slot_s;
  logic [9:0]         pwm_s;
  logic [11:0]        pulses_s;
  logic [7:0]         reps_s;
  logic [10:0]        pwm_inc;
  logic               boost_o, ended, done, skip_gap;

  function automatic logic [2:0] phase_code(input bpsq_pkg::phase_t p);
    logic [2:0] c;
    case (p)
      bpsq_pkg::PH_BOOST_A:   c = bpsq_pkg::PHASE_CODE_BOOST_A;
      bpsq_pkg::PH_TRIG_A:    c = bpsq_pkg::PHASE_CODE_TRIG_A;
      bpsq_pkg::PH_BOOST_B:   c = bpsq_pkg::PHASE_CODE_BOOST_B;
      bpsq_pkg::PH_TRIG_B:    c = bpsq_pkg::PHASE_CODE_TRIG_B;
      bpsq_pkg::PH_GAP_TRIG:  c = bpsq_pkg::PHASE_CODE_GAP_TRIG;
      bpsq_pkg::PH_GAP_SENSE: c = bpsq_pkg::PHASE_CODE_GAP_SENSE;
      default:                c = bpsq_pkg::PHASE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // Resolve the phase actually entered when starting at p, skipping every
  // zero-length phase. A skipped trigger gap closes one repetition; if no
  // boost, trigger or trigger gap phase is live the remaining repetitions collapse.
  function automatic bpsq_pkg::enter_t enter_phase(
    input bpsq_pkg::phase_t p,
    input logic [7:0]       reps,
    input logic             skip,
    input logic             b_ok,
    input logic             t_ok,
    input logic             tg_ok,
    input logic             sg_ok
  );
    bpsq_pkg::enter_t r;
    logic             to_gap;
    logic [7:0]       reps_dec;
    r.phase  = bpsq_pkg::PH_IDLE;
    r.reps   = reps;
    to_gap   = 1'b0;
    reps_dec = (reps != 8'd0) ? reps - 8'd1 : 8'd0;
    case (p)
      bpsq_pkg::PH_BOOST_A: begin
        if (b_ok)      r.phase = bpsq_pkg::PH_BOOST_A;
        else if (t_ok) r.phase = bpsq_pkg::PH_TRIG_A;
        else           to_gap  = 1'b1;
      end
      bpsq_pkg::PH_TRIG_A: begin
        if (t_ok)      r.phase = bpsq_pkg::PH_TRIG_A;
        else if (b_ok) r.phase = bpsq_pkg::PH_BOOST_B;
        else           to_gap  = 1'b1;
      end
      bpsq_pkg::PH_BOOST_B: begin
        if (b_ok)      r.phase = bpsq_pkg::PH_BOOST_B;
        else if (t_ok) r.phase = bpsq_pkg::PH_TRIG_B;
        else           to_gap  = 1'b1;
      end
      bpsq_pkg::PH_TRIG_B: begin
        if (t_ok) r.phase = bpsq_pkg::PH_TRIG_B;
        else      to_gap  = 1'b1;
      end
      bpsq_pkg::PH_GAP_TRIG: to_gap = 1'b1;
      bpsq_pkg::PH_GAP_SENSE: begin
        if (sg_ok && !skip) r.phase = bpsq_pkg::PH_GAP_SENSE;
      end
      default: r.phase = bpsq_pkg::PH_IDLE;
    endcase
    if (to_gap) begin
      if (tg_ok && !skip) begin
        r.phase = bpsq_pkg::PH_GAP_TRIG;
      end else if (reps_dec != 8'd0 && b_ok) begin
        r.phase = bpsq_pkg::PH_BOOST_A;
        r.reps  = reps_dec;
      end else if (reps_dec != 8'd0 && t_ok) begin
        r.phase = bpsq_pkg::PH_TRIG_A;
        r.reps  = reps_dec;
      end else if (reps_dec != 8'd0 && tg_ok) begin
        // Only the trigger gap of the next pair is live
        r.phase = bpsq_pkg::PH_GAP_TRIG;
        r.reps  = reps_dec;
      end else begin
        r.reps  = 8'd0;
        r.phase = sg_ok ? bpsq_pkg::PH_GAP_SENSE : bpsq_pkg::PH_IDLE;
      end
    end
    return r;
  endfunction

  assign in_accept = in_tvalid & in_tready;
  assign in_tready = ~out_valid_r | out_tready;

  always_comb begin
    lvl_sat = (32'(cfg.intensity_level) > bpsq_pkg::MAX_LEVEL) ?
              4'(bpsq_pkg::MAX_LEVEL) : cfg.intensity_level;
    boost_slots = 12'(cfg.pulses_per_level) * 12'(lvl_sat);
    boost_ok    = (cfg.pulses_per_level != 8'd0) && (lvl_sat != 4'd0);
    trig_ok     = (cfg.trig_width_us != 16'd0);
    tgap_ok     = (cfg.trig_gap_us != '0);
    sgap_ok     = (cfg.sense_gap_us != '0);
    if (cfg.boost_period == 11'd0)
      pwm_period = 11'd1;
    else if (32'(cfg.boost_period) > bpsq_pkg::PWM_MAX_PERIOD)
      pwm_period = 11'(bpsq_pkg::PWM_MAX_PERIOD);
    else
      pwm_period = cfg.boost_period;
  end

  always_comb begin
    start = (phase_r == bpsq_pkg::PH_IDLE) && in_tdata[0];
    ent0  = enter_phase((cfg.pair_count != 8'd0) ? bpsq_pkg::PH_BOOST_A
                                                 : bpsq_pkg::PH_GAP_SENSE,
                        cfg.pair_count, 1'b0, boost_ok, trig_ok, tgap_ok, sgap_ok);

    // State after a possible start
    ph       = phase_r;
    timer_s  = timer_r;
    slot_s   = slot_r;
    pwm_s    = pwm_r;
    pulses_s = pulses_r;
    reps_s   = reps_r;
    if (start) begin
      ph     = ent0.phase;
      reps_s = ent0.reps;
      case (ent0.phase)
        bpsq_pkg::PH_BOOST_A, bpsq_pkg::PH_BOOST_B: begin
          pulses_s = boost_slots;
          slot_s   = 11'd0;
          pwm_s    = 10'd0;
        end
        bpsq_pkg::PH_TRIG_A, bpsq_pkg::PH_TRIG_B: timer_s = GB'(cfg.trig_width_us);
        bpsq_pkg::PH_GAP_TRIG:  timer_s = cfg.trig_gap_us;
        bpsq_pkg::PH_GAP_SENSE: timer_s = cfg.sense_gap_us;
        default: timer_s = timer_r;
      endcase
    end

    // Advance the current phase by one tick
    timer_nxt  = timer_s;
    slot_nxt   = slot_s;
    pwm_nxt    = pwm_s;
    pulses_nxt = pulses_s;
    boost_o    = 1'b0;
    ended      = 1'b0;
    pwm_inc    = 11'(pwm_s) + 11'd1;
    case (ph)
      bpsq_pkg::PH_BOOST_A, bpsq_pkg::PH_BOOST_B: begin
        boost_o = (11'(pwm_s) < cfg.boost_on_ticks);
        pwm_nxt = (pwm_inc >= pwm_period) ? 10'd0 : pwm_inc[9:0];
        if (slot_s >= cfg.boost_period) begin
          slot_nxt   = 11'd0;
          pulses_nxt = (pulses_s != 12'd0) ? pulses_s - 12'd1 : 12'd0;
          ended      = (pulses_nxt == 12'd0);
        end else begin
          slot_nxt = slot_s + 11'd1;
        end
      end
      bpsq_pkg::PH_TRIG_A, bpsq_pkg::PH_TRIG_B, bpsq_pkg::PH_GAP_TRIG,
      bpsq_pkg::PH_GAP_SENSE: begin
        timer_nxt = (timer_s != '0) ? timer_s - GB'(1) : '0;
        ended     = (timer_nxt == '0);
      end
      default: ended = 1'b0;
    endcase

    // Pick the following phase; a finished gap skips itself on re-entry
    case (ph)
      bpsq_pkg::PH_BOOST_A: next_ph = bpsq_pkg::PH_TRIG_A;
      bpsq_pkg::PH_TRIG_A:  next_ph = bpsq_pkg::PH_BOOST_B;
      bpsq_pkg::PH_BOOST_B: next_ph = bpsq_pkg::PH_TRIG_B;
      bpsq_pkg::PH_TRIG_B:  next_ph = bpsq_pkg::PH_GAP_TRIG;
      default:              next_ph = ph;
    endcase
    skip_gap = (ph == bpsq_pkg::PH_GAP_TRIG) || (ph == bpsq_pkg::PH_GAP_SENSE);
    ent1 = enter_phase(next_ph, reps_s, skip_gap, boost_ok, trig_ok, tgap_ok, sgap_ok);

    phase_nxt = ph;
    reps_nxt  = reps_s;
    if (ended) begin
      phase_nxt = ent1.phase;
      reps_nxt  = ent1.reps;
      case (ent1.phase)
        bpsq_pkg::PH_BOOST_A, bpsq_pkg::PH_BOOST_B: begin
          pulses_nxt = boost_slots;
          slot_nxt   = 11'd0;
          pwm_nxt    = 10'd0;
        end
        bpsq_pkg::PH_TRIG_A, bpsq_pkg::PH_TRIG_B: timer_nxt = GB'(cfg.trig_width_us);
        bpsq_pkg::PH_GAP_TRIG:  timer_nxt = cfg.trig_gap_us;
        bpsq_pkg::PH_GAP_SENSE: timer_nxt = cfg.sense_gap_us;
        default: timer_nxt = timer_nxt;
      endcase
    end

    done = (start && ent0.phase == bpsq_pkg::PH_IDLE) ||
           (ended && ent1.phase == bpsq_pkg::PH_IDLE);

    out_data_nxt = {2'b00, phase_code(ph),
                    (ph == bpsq_pkg::PH_TRIG_B), (ph == bpsq_pkg::PH_TRIG_A), boost_o};
    out_last_nxt = done;

    if (in_accept)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bpsq_pkg::PH_IDLE;
      timer_r     <= '0;
      slot_r      <= 11'd0;
      pwm_r       <= 10'd0;
      pulses_r    <= 12'd0;
      reps_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r  <= phase_nxt;
        timer_r  <= timer_nxt;
        slot_r   <= slot_nxt;
        pwm_r    <= pwm_nxt;
        pulses_r <= pulses_nxt;
        reps_r   <= reps_nxt;
      end
    end
  end

  // Payload only loads with a transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### hdl/bpsq_checker.sv
`include "biphasic_stim_pulse_sequencer_core_assert.svh"

module bpsq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result stays put
  `BPSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // An empty output register never blocks the input
  `BPSQ_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // Boost, positive and negative drives are mutually exclusive
  `BPSQ_ASSERT_NOW(a_drive_excl, clk, rst_n, out_tvalid, $onehot0(out_tdata[2:0]))

  // Idle ticks drive nothing
  `BPSQ_ASSERT_NOW(a_idle_quiet, clk, rst_n, out_tvalid && out_tdata[5:3] == bpsq_pkg::PHASE_CODE_IDLE, out_tdata[2:0] == 3'b000)

endmodule

bind biphasic_stim_pulse_sequencer_core bpsq_checker u_bpsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
